FILE: design/hashed_page_table_group_manager_macros.svh
// Assertion macros for the hashed page table group manager.
`ifndef HASHED_PAGE_TABLE_GROUP_MANAGER_MACROS_SVH
`define HASHED_PAGE_TABLE_GROUP_MANAGER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge while out of reset.
`define HPTGM_ASSERT(name, prop, clk, rstn) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hptgm assertion failed");

// Checked on every rising edge, reset included.
`define HPTGM_ASSERT_ALWAYS(name, prop, clk) \
  name: assert property (@(posedge clk) prop) \
    else $error("hptgm assertion failed");

`else

`define HPTGM_ASSERT(name, prop, clk, rstn)
`define HPTGM_ASSERT_ALWAYS(name, prop, clk)

`endif

`endif

FILE: design/hptgm_pkg.sv
// Types and constants of the hashed page table group manager.
package hptgm_pkg;

  localparam int GROUP_COUNT     = 256;
  localparam int REAL_PAGE_BITS  = 40;
  localparam int SLOTS_PER_GROUP = 8;
  localparam int SLOT_BITS       = $clog2(SLOTS_PER_GROUP);
  localparam int GROUP_BITS      = $clog2(GROUP_COUNT);
  localparam int ENTRY_BITS      = GROUP_BITS + SLOT_BITS;
  localparam int ENTRY_COUNT     = GROUP_COUNT * SLOTS_PER_GROUP;
  localparam int TAG_SHIFT       = 23;
  localparam int VA_BITS         = 64;
  localparam int AVPN_BITS       = VA_BITS - TAG_SHIFT;
  localparam int FLAG_BITS       = 12;
  localparam int PROT_BITS       = 3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_INVAL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic                 valid;
    logic [AVPN_BITS-1:0] avpn;
    logic                 secondary;
    logic                 bolted;
    logic                 large_pg;
  } tag_entry_t;

  typedef tag_entry_t [SLOTS_PER_GROUP-1:0] tag_row_t;

  typedef struct packed {
    logic [REAL_PAGE_BITS-1:0] rpn;
    logic [FLAG_BITS-1:0]      flags;
  } data_entry_t;

endpackage

FILE: design/hashed_page_table_group_manager.sv
// Hashed page table group manager: tag/data memories with read-modify-write control.
// Sequence: a transaction is accepted and its group row is read into tag_rd_q; then,
//   once the output register has room, the row is modified, written back and the
//   result lands in the output register. A new transaction is accepted only after
//   the last is written back; a result not taken stalls the write-back.
// Reset: the tag memory is swept to invalid, one group row a cycle, over all
//   GROUP_COUNT (256) rows after reset, with in_ready_o low throughout.
`include "hashed_page_table_group_manager_macros.svh"

module hashed_page_table_group_manager import hptgm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  group_index_i,
  input  logic [10:0] slot_index_i,
  input  logic [63:0] virt_addr_i,
  input  logic [39:0] real_page_i,
  input  logic        use_secondary_i,
  input  logic [11:0] page_flags_i,
  input  logic        pinned_i,
  input  logic        large_page_i,
  input  logic [2:0]  new_protection_i,
  input  logic [2:0]  start_offset_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [3:0]  slot_result_o,
  output logic        flush_tlb_o,
  output logic        flush_large_o
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [GROUP_BITS-1:0] clr_q, clr_d;
  logic                  out_valid_q, out_valid_d;

  // Captured transaction (payload, no reset)
  op_e                       op_q;
  logic [GROUP_BITS-1:0]     row_addr_q;
  logic [SLOT_BITS-1:0]      sel_q;      // slot within row for update/invalidate
  logic [SLOT_BITS-1:0]      off_q;      // first slot probed by remove
  logic [AVPN_BITS-1:0]      tag_q;      // large-adjusted abbreviated VPN
  logic [REAL_PAGE_BITS-1:0] rpn_q;
  logic                      sec_q;
  logic [FLAG_BITS-1:0]      flags_q;
  logic                      bolt_q;
  logic                      large_q;
  logic [PROT_BITS-1:0]      newpp_q;

  // Result register (payload, no reset)
  logic                      status_q;
  logic [3:0]                slot_res_q;
  logic                      flush_q;
  logic                      flush_large_q;

  // Memories and their read registers
  tag_row_t    tag_mem  [GROUP_COUNT];
  data_entry_t data_mem [ENTRY_COUNT];
  tag_row_t    tag_rd_q;
  data_entry_t data_rd_q;

  logic                  acc;
  op_e                   op_in;
  logic [GROUP_BITS-1:0] row_raddr;
  logic                  exec_fire;

  // Write-back side, from the combinational block
  logic                  tag_we, tag_upd;
  logic [GROUP_BITS-1:0] tag_waddr;
  tag_row_t              tag_wdata, row_mod;
  logic                  data_we;
  logic [ENTRY_BITS-1:0] data_waddr;
  data_entry_t           data_wdata;

  // Result of the current transaction
  logic       res_status;
  logic [3:0] res_slot;

  // Group search results
  logic                 free_hit, rm_hit, tag_hit;
  logic [SLOT_BITS-1:0] free_idx, rm_pos, rm_cnt;
  tag_entry_t           sel_entry;

  assign op_in      = op_e'(op_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  // update and invalidate address one entry, insert and remove a whole group
  assign row_raddr  = (op_in == OP_UPDATE || op_in == OP_INVAL)
                    ? slot_index_i[ENTRY_BITS-1:SLOT_BITS]
                    : group_index_i[GROUP_BITS-1:0];
  // write-back only when the output register has room for the result
  assign exec_fire  = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == GROUP_BITS'(GROUP_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Transaction capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q       <= op_in;
      row_addr_q <= row_raddr;
      sel_q      <= slot_index_i[SLOT_BITS-1:0];
      off_q      <= start_offset_i;
      tag_q      <= {virt_addr_i[VA_BITS-1:TAG_SHIFT+1],
                     virt_addr_i[TAG_SHIFT] & ~large_page_i};
      rpn_q      <= REAL_PAGE_BITS'(real_page_i);
      sec_q      <= use_secondary_i;
      flags_q    <= page_flags_i;
      bolt_q     <= pinned_i;
      large_q    <= large_page_i;
      newpp_q    <= new_protection_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: one write and one registered read per cycle each
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      tag_rd_q <= tag_mem[row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      data_rd_q <= data_mem[slot_index_i[ENTRY_BITS-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Group search over the row just read
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [SLOT_BITS-1:0] pos;
    free_hit = 1'b0;
    free_idx = '0;
    rm_hit   = 1'b0;
    rm_pos   = '0;
    rm_cnt   = '0;
    // walk downwards so the lowest index / fewest probes wins
    for (int k = SLOTS_PER_GROUP - 1; k >= 0; k--) begin
      if (!tag_rd_q[k].valid) begin
        free_hit = 1'b1;
        free_idx = SLOT_BITS'(k);
      end
      pos = off_q + SLOT_BITS'(k);
      if (tag_rd_q[pos].valid && !tag_rd_q[pos].bolted) begin
        rm_hit = 1'b1;
        rm_pos = pos;
        rm_cnt = SLOT_BITS'(k);
      end
    end
    sel_entry = tag_rd_q[sel_q];
    tag_hit   = sel_entry.valid && (sel_entry.avpn == tag_q);
  end

  // ---------------------------------------------------------------------------
  // Modify: new row, data write and result
  // ---------------------------------------------------------------------------
  always_comb begin
    row_mod    = tag_rd_q;
    tag_upd    = 1'b0;
    data_we    = 1'b0;
    data_waddr = {row_addr_q, sel_q};
    data_wdata = data_rd_q;
    res_status = STATUS_FAIL;
    res_slot   = '0;
    case (op_q)
      OP_INSERT: begin
        if (free_hit) begin
          row_mod[free_idx] = '{valid: 1'b1, avpn: tag_q, secondary: sec_q,
                                bolted: bolt_q, large_pg: large_q};
          tag_upd    = 1'b1;
          data_we    = exec_fire;
          data_waddr = {row_addr_q, free_idx};
          data_wdata = '{rpn: rpn_q, flags: flags_q};
          res_status = STATUS_OK;
          res_slot   = {sec_q, free_idx};
        end
      end
      OP_REMOVE: begin
        if (rm_hit) begin
          row_mod[rm_pos] = '0;
          tag_upd         = 1'b1;
          res_status      = STATUS_OK;
          res_slot        = {1'b0, rm_cnt};
        end
      end
      OP_UPDATE: begin
        if (tag_hit) begin
          data_we    = exec_fire;
          data_wdata = '{rpn:   data_rd_q.rpn,
                         flags: {data_rd_q.flags[FLAG_BITS-1:PROT_BITS], newpp_q}};
          res_status = STATUS_OK;
        end
      end
      OP_INVAL: begin
        if (tag_hit) begin
          row_mod[sel_q] = '0;
          tag_upd        = 1'b1;
          res_status     = STATUS_OK;
        end
      end
      default: begin
        res_status = STATUS_FAIL;
      end
    endcase
  end

  // clearing sweep owns the tag write port until it finishes
  assign tag_we    = (state_q == ST_CLEAR) || (exec_fire && tag_upd);
  assign tag_waddr = (state_q == ST_CLEAR) ? clr_q : row_addr_q;
  assign tag_wdata = (state_q == ST_CLEAR) ? '0 : row_mod;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      status_q      <= res_status;
      slot_res_q    <= res_slot;
      flush_q       <= (op_q == OP_UPDATE || op_q == OP_INVAL);
      flush_large_q <= (op_q == OP_UPDATE || op_q == OP_INVAL) && large_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_result_o = slot_res_q;
  assign flush_tlb_o   = flush_q;
  assign flush_large_o = flush_large_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HPTGM_ASSERT(a_accept_to_exec, acc |=> (state_q == ST_EXEC), clk_i, rst_ni)
  `HPTGM_ASSERT(a_no_idle_write, (state_q == ST_IDLE) |-> (!tag_we && !data_we), clk_i, rst_ni)
  `HPTGM_ASSERT(a_result_from_exec, $rose(out_valid_o) |-> $past(exec_fire), clk_i, rst_ni)
  `HPTGM_ASSERT(a_large_implies_flush, out_valid_o && flush_large_o |-> flush_tlb_o, clk_i, rst_ni)
  `HPTGM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!out_valid_o && !in_ready_o), clk_i)

endmodule
